[hw/rtl/datediff_pkg.sv]
// Shared types and constants for the date difference pipeline.
// No dependencies; imported by datediff_ordinal and date_difference_days_top.
package datediff_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 23;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   // months before March get no leap day
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // floor(n / 100) = (n * DIV100_MUL) >> DIV100_SHIFT, exact for n < 43690
   localparam int DIV100_MUL_W = 13;
   localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
   localparam int DIV100_SHIFT = 19;
   localparam int QUOT_W       = 8;
   localparam logic [YEAR_W-1:0] CENTURY = 14'd100;
   localparam logic [YEAR_W-1:0] REM_LAST = 14'd99;
   localparam logic [YEAR_W-1:0] DAYS_PER_YEAR = 14'd365;

   localparam int MONTH_DAYS_W = 9;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   function automatic logic [MONTH_DAYS_W-1:0] days_before_month(
      input logic [MONTH_W-1:0] m
   );
      logic [MONTH_DAYS_W-1:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/datediff_ordinal.sv]
// Four-stage datapath turning one year/month/day into its ordinal day number.
// Uses datediff_pkg; stage loads come from the top level's flow control.
module datediff_ordinal #(
   parameter int YEAR_MAX = 9999,
   parameter int ORD_W    = 22
) (
   input  logic                           clock,
   input  datediff_pkg::stage_en_type     stage_en,
   input  logic [datediff_pkg::YEAR_W-1:0]  year,
   input  logic [datediff_pkg::MONTH_W-1:0] month,
   input  logic [datediff_pkg::DAY_W-1:0]   day,
   output logic [ORD_W-1:0]               ordinal
);
   import datediff_pkg::*;

   localparam int YEAR_TOP = (YEAR_MAX < (2 ** YEAR_W) - 1) ? YEAR_MAX : (2 ** YEAR_W) - 1;
   localparam int PROD_W   = YEAR_W + DIV100_MUL_W;

   // stage 1: clamped fields, n = year - 1
   logic [YEAR_W-1:0]  n1_ff, n1_in;
   logic [MONTH_W-1:0] m1_ff, m1_in;
   logic [DAY_W-1:0]   d1_ff;
   // stage 2: centuries and n * 365
   logic [YEAR_W-1:0]  n2_ff;
   logic [MONTH_W-1:0] m2_ff;
   logic [DAY_W-1:0]   d2_ff;
   logic [QUOT_W-1:0]  q2_ff;
   logic [ORD_W-1:0]   n365_ff;
   logic [PROD_W-1:0]  prod;
   // stage 3: days of earlier years, days of earlier months plus day
   logic [ORD_W-1:0]        years_ff, years_in;
   logic [MONTH_DAYS_W-1:0] months_ff, months_in;
   logic [YEAR_W-1:0]       rem;
   logic                    leap;
   // stage 4
   logic [ORD_W-1:0] ord_ff;

   logic [YEAR_W-1:0] y_clamp;

   always_comb begin
      y_clamp = year;
      if (year == '0) begin
         y_clamp = YEAR_W'(1);
      end
      if (int'(year) > YEAR_TOP) begin
         y_clamp = YEAR_W'(YEAR_TOP);
      end
      n1_in = y_clamp - YEAR_W'(1);
      m1_in = month;
      if (month < MONTH_JAN) begin
         m1_in = MONTH_JAN;
      end
      if (month > MONTH_DEC) begin
         m1_in = MONTH_DEC;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         n1_ff <= n1_in;
         m1_ff <= m1_in;
         d1_ff <= day;
      end
   end

   assign prod = PROD_W'(n1_ff) * PROD_W'(DIV100_MUL);

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         n2_ff   <= n1_ff;
         m2_ff   <= m1_ff;
         d2_ff   <= d1_ff;
         q2_ff   <= prod[DIV100_SHIFT +: QUOT_W];
         n365_ff <= ORD_W'(n1_ff) * ORD_W'(DAYS_PER_YEAR);
      end
   end

   // year = n + 1 is leap when n % 4 == 3, except n % 100 == 99 needs n % 400 == 399
   always_comb begin
      rem = n2_ff - YEAR_W'(q2_ff) * CENTURY;
      if (rem == REM_LAST) begin
         leap = (q2_ff[1:0] == 2'b11);
      end else begin
         leap = (n2_ff[1:0] == 2'b11);
      end
      years_in = n365_ff + ORD_W'(n2_ff >> 2) - ORD_W'(q2_ff) + ORD_W'(q2_ff >> 2);
      months_in = days_before_month(m2_ff) + MONTH_DAYS_W'(d2_ff)
                + MONTH_DAYS_W'(leap && (m2_ff > MONTH_FEB));
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         years_ff  <= years_in;
         months_ff <= months_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         ord_ff <= years_ff + ORD_W'(months_ff);
      end
   end

   assign ordinal = ord_ff;

endmodule

[hw/rtl/date_difference_days_top.sv]
// Top level of the date difference block: stream ports, flow control, subtract stage.
// Uses datediff_pkg and two datediff_ordinal pipelines.

// Days between two Gregorian dates. Each request carries a start and an end
// date; the response is the signed day count from start to end (negative when
// the end date is earlier), leap years by the 4/100/400 rule. Years are
// clamped to 1..YEAR_MAX and months to 1..12; the day is added unchecked, so
// day 0 is the last day of the month before. One transfer is taken every
// cycle while req_tready is high; each result passes through five register
// stages (clamp, divide by 100 and multiply by 365, year and month
// sums, ordinal add, subtract). Each stage holds its item while the next is
// full, so bubbles close up and a stalled response does not stop new requests
// until the pipeline is full.
module date_difference_days_top #(
   parameter int YEAR_MAX = 9999
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // start_year, start_month, start_day, end_year, end_month, end_day, zero pad
   input  logic [datediff_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // day_count (signed), zero pad
   output logic [datediff_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import datediff_pkg::*;

   localparam int YEAR_TOP = (YEAR_MAX < (2 ** YEAR_W) - 1) ? YEAR_MAX : (2 ** YEAR_W) - 1;
   localparam int ORD_W    = $clog2(YEAR_TOP * 366 + 32);
   localparam int DIFF_W   = (ORD_W + 1 > COUNT_W) ? ORD_W + 1 : COUNT_W;

   localparam int SY_LO = 0;
   localparam int SM_LO = SY_LO + YEAR_W;
   localparam int SD_LO = SM_LO + MONTH_W;
   localparam int EY_LO = SD_LO + DAY_W;
   localparam int EM_LO = EY_LO + YEAR_W;
   localparam int ED_LO = EM_LO + MONTH_W;

   logic [4:0] valid_ff, valid_in;
   logic [4:0] ready;
   stage_en_type stage_en;

   logic [ORD_W-1:0]   start_ord, end_ord;
   logic [COUNT_W-1:0] count_ff;
   logic [DIFF_W-1:0]  diff;

   // a stage loads when it is empty or its successor takes its item this cycle
   always_comb begin
      ready[4] = !valid_ff[4] || rsp_tready;
      for (int i = 3; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in[0] = ready[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < 5; i++) begin
         valid_in[i] = ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
      stage_en.s1 = ready[0];
      stage_en.s2 = ready[1];
      stage_en.s3 = ready[2];
      stage_en.s4 = ready[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   datediff_ordinal #(
      .YEAR_MAX (YEAR_MAX),
      .ORD_W    (ORD_W)
   ) u_start (
      .clock    (clock),
      .stage_en (stage_en),
      .year     (req_tdata[SY_LO +: YEAR_W]),
      .month    (req_tdata[SM_LO +: MONTH_W]),
      .day      (req_tdata[SD_LO +: DAY_W]),
      .ordinal  (start_ord)
   );

   datediff_ordinal #(
      .YEAR_MAX (YEAR_MAX),
      .ORD_W    (ORD_W)
   ) u_end (
      .clock    (clock),
      .stage_en (stage_en),
      .year     (req_tdata[EY_LO +: YEAR_W]),
      .month    (req_tdata[EM_LO +: MONTH_W]),
      .day      (req_tdata[ED_LO +: DAY_W]),
      .ordinal  (end_ord)
   );

   // wrap to the output width in two's complement
   assign diff = DIFF_W'(end_ord) - DIFF_W'(start_ord);

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         count_ff <= diff[COUNT_W-1:0];
      end
   end

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[4];
   assign rsp_tdata  = {{(RSP_DATA_W - COUNT_W){1'b0}}, count_ff};

endmodule
